@@ hdl/aioc_pkg.sv @@
// Shared types, codes and a helper function of the arcade I/O command controller.
package aioc_pkg;

	// Access kinds carried in the cmd field.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DIP_WORD_A      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DIP_WORD_B      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_INTERRUPT_DELAY = 2'd2;

	localparam logic [7:0] INTERRUPT_DELAY_RESET = 8'd30;

	// Command byte codes.
	localparam logic [7:0] CMD_MODE_SET    = 8'ha1;
	localparam logic [7:0] CMD_MODE_CLR_A  = 8'hc1;
	localparam logic [7:0] CMD_MODE_CLR_B  = 8'he1;
	localparam logic [7:0] CMD_NO_DELAY    = 8'h10;
	localparam logic [7:0] CMD_CONTROLS    = 8'h71;
	localparam logic [7:0] CMD_DIP         = 8'hd2;
	localparam logic [7:0] CMD_ZERO_PORTS  = 8'hb1;

	// Port numbers on the low address bits.
	localparam logic [3:0] PORT_0 = 4'd0;
	localparam logic [3:0] PORT_1 = 4'd1;
	localparam logic [3:0] PORT_2 = 4'd2;

	localparam logic [7:0] BYTE_IDLE      = 8'hff;
	localparam logic [7:0] BYTE_ZERO      = 8'h00;
	localparam logic [7:0] BYTE_PORT2_STD = 8'hf8;

	// Direction codes in standard mode.
	localparam logic [3:0] DIR_UP    = 4'hf;
	localparam logic [3:0] DIR_RIGHT = 4'hd;
	localparam logic [3:0] DIR_DOWN  = 4'hb;
	localparam logic [3:0] DIR_LEFT  = 4'h9;
	localparam logic [3:0] DIR_NONE  = 4'h7;

	localparam logic [6:0] CREDIT_MAX = 7'd99;

	// Button bit positions.
	localparam int unsigned BTN_UP    = 0;
	localparam int unsigned BTN_DOWN  = 1;
	localparam int unsigned BTN_LEFT  = 2;
	localparam int unsigned BTN_RIGHT = 3;
	localparam int unsigned BTN_FIRE  = 4;
	localparam int unsigned BTN_START = 5;
	localparam int unsigned BTN_COIN  = 6;

	typedef struct packed {
		logic       cmd;
		logic [8:0] addr;
		logic [7:0] write_data;
		logic [6:0] buttons;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [6:0] credit_count;
		logic [7:0] interrupt_countdown;
	} rsp_t;

	// Two-digit BCD of a value up to 99. The tens digit comes from a
	// multiply by 205/2048, which is exact for this range.
	function automatic logic [7:0] to_bcd(input logic [6:0] value);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  tens_x10;
		logic [6:0]  ones;
		prod     = 15'(value) * 15'd205;
		tens     = prod[14:11];
		tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
		ones     = value - tens_x10;
		return {tens, ones[3:0]};
	endfunction

endpackage

@@ hdl/aioc_stream_if.sv @@
// Valid/ready channel carrying one payload per transaction.
interface aioc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/arcade_io_command_controller.sv @@
// An accepted request goes to the input register, then its response to the result register.
// One request per cycle unless rsp stalls; decode and credit update fit between the registers.
// A response waiting in the result register does not stall the input register until it is full.
// Reset (arst_n low, asynchronous) clears the command, mode, countdown, credits and button
// history, sets dip_word_a/b to 0 and interrupt_delay to 30, and empties both registers.
module arcade_io_command_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	aioc_stream_if.sink                     req,
	aioc_stream_if.source                   rsp,
	input  logic                            cfg_wr_en,
	input  logic [aioc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_wr_data
);

	// Configuration registers.
	logic [7:0] dip_word_a_q, dip_word_b_q, interrupt_delay_q;

	// Block state.
	logic [7:0] command_q;
	logic       switch_mode_q;
	logic [7:0] countdown_q;
	logic [6:0] credits_q;
	logic [6:0] buttons_prev_q, buttons_prev2_q;

	// Input register and result register.
	aioc_pkg::req_t req_s1;
	logic           valid_s1;
	aioc_pkg::rsp_t rsp_s2;
	logic           valid_s2;

	logic advance;

	// Next-state and result of the item held in the input register.
	logic [7:0] command_d;
	logic       switch_mode_d;
	logic [7:0] countdown_d;
	logic [6:0] credits_d;
	logic [6:0] buttons_prev_d, buttons_prev2_d;
	logic [7:0] read_data_d;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dip_word_a_q      <= 8'd0;
			dip_word_b_q      <= 8'd0;
			interrupt_delay_q <= aioc_pkg::INTERRUPT_DELAY_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				aioc_pkg::CFG_DIP_WORD_A:      dip_word_a_q      <= cfg_wr_data;
				aioc_pkg::CFG_DIP_WORD_B:      dip_word_b_q      <= cfg_wr_data;
				aioc_pkg::CFG_INTERRUPT_DELAY: interrupt_delay_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [6:0] now, last, older, pulse;
		logic [6:0] cred;
		logic [3:0] port;
		logic [3:0] dir;
		now   = req_s1.buttons;
		last  = buttons_prev_q;
		older = buttons_prev2_q;
		pulse = (now ^ older) & now;
		port  = req_s1.addr[3:0];

		command_d       = command_q;
		switch_mode_d   = switch_mode_q;
		countdown_d     = countdown_q;
		credits_d       = credits_q;
		buttons_prev_d  = buttons_prev_q;
		buttons_prev2_d = buttons_prev2_q;
		read_data_d     = aioc_pkg::BYTE_ZERO;
		cred            = credits_q;
		dir             = aioc_pkg::DIR_NONE;

		if (req_s1.cmd == aioc_pkg::CMD_WRITE) begin
			if (req_s1.addr[8]) begin
				command_d = req_s1.write_data;
				if (req_s1.write_data == aioc_pkg::CMD_MODE_SET)
					switch_mode_d = 1'b1;
				if (req_s1.write_data == aioc_pkg::CMD_MODE_CLR_A ||
				    req_s1.write_data == aioc_pkg::CMD_MODE_CLR_B)
					switch_mode_d = 1'b0;
				countdown_d = (req_s1.write_data != aioc_pkg::CMD_NO_DELAY) ?
				              interrupt_delay_q : 8'd0;
			end
		end else if (req_s1.addr[8]) begin
			read_data_d = command_q;
		end else begin
			buttons_prev2_d = last;
			buttons_prev_d  = now;
			if (now[aioc_pkg::BTN_COIN] && !last[aioc_pkg::BTN_COIN] &&
			    cred < aioc_pkg::CREDIT_MAX)
				cred = cred + 7'd1;
			if (now[aioc_pkg::BTN_START] && !last[aioc_pkg::BTN_START] && cred != 7'd0)
				cred = cred - 7'd1;
			credits_d = cred;

			if (now[aioc_pkg::BTN_UP])         dir = aioc_pkg::DIR_UP;
			else if (now[aioc_pkg::BTN_RIGHT]) dir = aioc_pkg::DIR_RIGHT;
			else if (now[aioc_pkg::BTN_DOWN])  dir = aioc_pkg::DIR_DOWN;
			else if (now[aioc_pkg::BTN_LEFT])  dir = aioc_pkg::DIR_LEFT;

			read_data_d = aioc_pkg::BYTE_IDLE;
			case (command_q)
				aioc_pkg::CMD_CONTROLS: begin
					if (switch_mode_q) begin
						case (port)
							aioc_pkg::PORT_0: read_data_d = ~{3'b000,
								now[aioc_pkg::BTN_START], 3'b000, now[aioc_pkg::BTN_COIN]};
							aioc_pkg::PORT_1: read_data_d = ~{2'b00,
								last[aioc_pkg::BTN_FIRE], pulse[aioc_pkg::BTN_FIRE],
								now[aioc_pkg::BTN_LEFT], now[aioc_pkg::BTN_DOWN],
								now[aioc_pkg::BTN_RIGHT], now[aioc_pkg::BTN_UP]};
							default: read_data_d = aioc_pkg::BYTE_IDLE;
						endcase
					end else begin
						case (port)
							aioc_pkg::PORT_0: read_data_d = aioc_pkg::to_bcd(cred);
							aioc_pkg::PORT_1: read_data_d = ~{2'b00,
								now[aioc_pkg::BTN_FIRE], pulse[aioc_pkg::BTN_FIRE], dir};
							aioc_pkg::PORT_2: read_data_d = aioc_pkg::BYTE_PORT2_STD;
							default: read_data_d = aioc_pkg::BYTE_IDLE;
						endcase
					end
				end
				aioc_pkg::CMD_DIP: begin
					case (port)
						aioc_pkg::PORT_0: read_data_d = ~dip_word_a_q;
						aioc_pkg::PORT_1: read_data_d = ~dip_word_b_q;
						default: read_data_d = aioc_pkg::BYTE_IDLE;
					endcase
				end
				aioc_pkg::CMD_ZERO_PORTS: begin
					read_data_d = (port <= aioc_pkg::PORT_2) ?
					              aioc_pkg::BYTE_ZERO : aioc_pkg::BYTE_IDLE;
				end
				default: read_data_d = aioc_pkg::BYTE_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
			command_q       <= 8'd0;
			switch_mode_q   <= 1'b0;
			countdown_q     <= 8'd0;
			credits_q       <= 7'd0;
			buttons_prev_q  <= 7'd0;
			buttons_prev2_q <= 7'd0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (advance) begin
				valid_s2        <= 1'b1;
				command_q       <= command_d;
				switch_mode_q   <= switch_mode_d;
				countdown_q     <= countdown_d;
				credits_q       <= credits_d;
				buttons_prev_q  <= buttons_prev_d;
				buttons_prev2_q <= buttons_prev2_d;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			req_s1 <= req.data;
		if (advance) begin
			rsp_s2.read_data           <= read_data_d;
			rsp_s2.credit_count        <= credits_d;
			rsp_s2.interrupt_countdown <= countdown_d;
		end
	end

endmodule
